// ===== src/gamma_contrast_ramp_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gamma/contrast ramp core
// Each use expands to a clocked check on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GAMMA_CONTRAST_RAMP_CORE_DEFINES_SVH
`define GAMMA_CONTRAST_RAMP_CORE_DEFINES_SVH

`ifndef SYNTH
`define GCR_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("gcr: assertion failed");
`define GCR_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gcr: assertion failed");
`else
`define GCR_CHECK(lbl, prop)
`define GCR_CHECK_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/gcr_pkg.sv =====
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types, register indexes and the exp2 factor table function.
// ----------------------------------------------------------------------------
package gcr_pkg;

	localparam int GCR_LOG_FRAC = 24;

	localparam logic [7:0] GCR_REG_GAMMA    = 8'd0;
	localparam logic [7:0] GCR_REG_CONTRAST = 8'd1;

	// result overrides that ride along with an item
	typedef struct packed {
		logic zero;
		logic full;
	} gcr_flags_t;

	// truncating integer square root, one result bit per iteration
	function automatic logic [63:0] gcr_isqrt(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v = v_in;
		res = '0;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// 2^(-2^-k) as Q0.32, by k nested square roots of 0.5
	function automatic logic [31:0] gcr_exp_tab(input int k);
		logic [63:0] c;
		c = 64'h0000_0000_8000_0000;
		for (int i = 1; i <= GCR_LOG_FRAC; i++) begin
			if (i <= k) begin
				c = gcr_isqrt({c[31:0], 32'h0});
			end
		end
		return c[31:0];
	endfunction

endpackage

// ===== src/gcr_div.sv =====
// ----------------------------------------------------------------------------
// gcr_div
// Pipelined restoring divider, one quotient bit per stage, N stages.
// ----------------------------------------------------------------------------
`include "gamma_contrast_ramp_core_defines.svh"

module gcr_div import gcr_pkg::*; #(
	parameter int N = 43,
	parameter int W = 15
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	input  logic [N-1:0] dividend,
	input  logic [W-1:0] divisor,
	input  gcr_flags_t   in_flags,
	output logic         out_valid,
	output logic [N-1:0] quotient,
	output gcr_flags_t   out_flags
);

	logic         vld_s [N];
	logic [W-1:0] rem_s [N];
	logic [N-1:0] acc_s [N];
	gcr_flags_t   flg_s [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [W-1:0] rem_i;
		logic [N-1:0] acc_i;
		logic         vld_i;
		gcr_flags_t   flg_i;
		logic [W:0]   trial;
		logic         ge;

		assign rem_i = (i == 0) ? '0 : rem_s[(i == 0) ? 0 : i - 1];
		assign acc_i = (i == 0) ? dividend : acc_s[(i == 0) ? 0 : i - 1];
		assign vld_i = (i == 0) ? in_valid : vld_s[(i == 0) ? 0 : i - 1];
		assign flg_i = (i == 0) ? in_flags : flg_s[(i == 0) ? 0 : i - 1];

		// remainder stays below divisor, so W+1 bits hold the trial
		assign trial = {rem_i, acc_i[N-1]};
		assign ge    = trial >= {1'b0, divisor};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? W'(trial - {1'b0, divisor}) : trial[W-1:0];
				acc_s[i] <= {acc_i[N-2:0], ge};
				flg_s[i] <= flg_i;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_i;
			end
		end

		`GCR_CHECK(a_rem_below_divisor, vld_s[i] |-> rem_s[i] < divisor)
	end

	assign out_valid = vld_s[N-1];
	assign quotient  = acc_s[N-1];
	assign out_flags = flg_s[N-1];

endmodule

// ===== src/gcr_log2.sv =====
// ----------------------------------------------------------------------------
// gcr_log2
// -log2(x) for Q0.32 x: leading one, normalize, then one squaring per stage.
// ----------------------------------------------------------------------------
`include "gamma_contrast_ramp_core_defines.svh"

module gcr_log2 import gcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] x,
	input  gcr_flags_t  in_flags,
	output logic        out_valid,
	output logic [29:0] t,
	output gcr_flags_t  out_flags
);

	localparam int F = GCR_LOG_FRAC;

	// leading-one stage
	logic [4:0]  p_c;
	logic [4:0]  p_s1;
	logic [31:0] x_s1;
	gcr_flags_t  flg_s1;
	logic        vld_s1;

	always_comb begin
		p_c = '0;
		for (int b = 1; b < 32; b++) begin
			if (x[b]) begin
				p_c = 5'(b);
			end
		end
	end

	// normalize stage: mantissa in Q1.30
	logic [30:0] m_c;
	logic [30:0] m_s2;
	logic [4:0]  p_s2;
	gcr_flags_t  flg_s2;
	logic        vld_s2;

	assign m_c = (p_s1 == 5'd31) ? x_s1[31:1] : 31'(x_s1 << (5'd30 - p_s1));

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1   <= p_c;
			x_s1   <= x;
			flg_s1 <= in_flags;
			m_s2   <= m_c;
			p_s2   <= p_s1;
			flg_s2 <= flg_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// squaring stages, one fraction bit each
	logic [30:0]  m_q   [F];
	logic [F-1:0] f_q   [F];
	logic [4:0]   p_q   [F];
	gcr_flags_t   flg_q [F];
	logic         vld_q [F];

	for (genvar i = 0; i < F; i++) begin : g_sq
		logic [30:0]  m_i;
		logic [F-1:0] f_i;
		logic [4:0]   p_i;
		gcr_flags_t   flg_i;
		logic         vld_i;
		logic [61:0]  sq;
		logic [31:0]  hi;

		assign m_i   = (i == 0) ? m_s2 : m_q[(i == 0) ? 0 : i - 1];
		assign f_i   = (i == 0) ? '0 : f_q[(i == 0) ? 0 : i - 1];
		assign p_i   = (i == 0) ? p_s2 : p_q[(i == 0) ? 0 : i - 1];
		assign flg_i = (i == 0) ? flg_s2 : flg_q[(i == 0) ? 0 : i - 1];
		assign vld_i = (i == 0) ? vld_s2 : vld_q[(i == 0) ? 0 : i - 1];

		assign sq = m_i * m_i;
		assign hi = sq[61:30];

		always_ff @(posedge clk) begin
			if (en) begin
				m_q[i]   <= hi[31] ? hi[31:1] : hi[30:0];
				f_q[i]   <= {f_i[F-2:0], hi[31]};
				p_q[i]   <= p_i;
				flg_q[i] <= flg_i;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (en) begin
				vld_q[i] <= vld_i;
			end
		end
	end

	// t = (32 - p) - fraction
	logic [29:0] t_s3;
	gcr_flags_t  flg_s3;
	logic        vld_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s3   <= {6'd32 - {1'b0, p_q[F-1]}, 24'h0} - {6'h0, f_q[F-1]};
			flg_s3 <= flg_q[F-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_q[F-1];
		end
	end

	assign out_valid = vld_s3;
	assign t         = t_s3;
	assign out_flags = flg_s3;

	`GCR_CHECK(a_mantissa_normalized, vld_s2 && !flg_s2.zero && !flg_s2.full |-> m_s2[30])

endmodule

// ===== src/gcr_exp2.sv =====
// ----------------------------------------------------------------------------
// gcr_exp2
// 2^-u by one constant-factor multiply per fraction bit, then shift and scale.
// ----------------------------------------------------------------------------
module gcr_exp2 import gcr_pkg::*; #(
	parameter int OUT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [4:0]          n,
	input  logic [23:0]         r,
	input  gcr_flags_t          in_flags,
	output logic                out_valid,
	output logic [OUT_BITS-1:0] level
);

	localparam int F = GCR_LOG_FRAC;
	localparam logic [OUT_BITS-1:0] MAXOUT = '1;

	logic [31:0]  y_q   [F];
	logic         one_q [F];
	logic [F-1:0] r_q   [F];
	logic [4:0]   n_q   [F];
	gcr_flags_t   flg_q [F];
	logic         vld_q [F];

	for (genvar i = 0; i < F; i++) begin : g_mul
		localparam logic [31:0] C = gcr_exp_tab(i + 1);
		logic [31:0]  y_i;
		logic         one_i;
		logic [F-1:0] r_i;
		logic [4:0]   n_i;
		gcr_flags_t   flg_i;
		logic         vld_i;
		logic [63:0]  prod;
		logic         sel;

		assign y_i   = (i == 0) ? '0 : y_q[(i == 0) ? 0 : i - 1];
		assign one_i = (i == 0) ? 1'b1 : one_q[(i == 0) ? 0 : i - 1];
		assign r_i   = (i == 0) ? r : r_q[(i == 0) ? 0 : i - 1];
		assign n_i   = (i == 0) ? n : n_q[(i == 0) ? 0 : i - 1];
		assign flg_i = (i == 0) ? in_flags : flg_q[(i == 0) ? 0 : i - 1];
		assign vld_i = (i == 0) ? in_valid : vld_q[(i == 0) ? 0 : i - 1];

		assign prod = y_i * C;
		assign sel  = r_i[F-1-i];

		// while y is still exactly one the product is the factor itself
		always_ff @(posedge clk) begin
			if (en) begin
				y_q[i]   <= sel ? (one_i ? C : prod[63:32]) : y_i;
				one_q[i] <= one_i & ~sel;
				r_q[i]   <= r_i;
				n_q[i]   <= n_i;
				flg_q[i] <= flg_i;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (en) begin
				vld_q[i] <= vld_i;
			end
		end
	end

	// integer part shift
	logic [32:0] ys_s1;
	gcr_flags_t  flg_s1;
	logic        vld_s1;

	// scale, round half up, saturate, apply overrides
	logic [OUT_BITS+33:0] scaled;
	logic [OUT_BITS+1:0]  res;
	logic [OUT_BITS-1:0]  lvl_c;
	logic [OUT_BITS-1:0]  lvl_s2;
	logic                 vld_s2;

	assign scaled = ys_s1 * MAXOUT + (OUT_BITS+34)'(64'h8000_0000);
	assign res    = scaled[OUT_BITS+33:32];

	always_comb begin
		priority if (flg_s1.full) begin
			lvl_c = MAXOUT;
		end else if (flg_s1.zero) begin
			lvl_c = '0;
		end else if (res > (OUT_BITS+2)'(MAXOUT)) begin
			lvl_c = MAXOUT;
		end else begin
			lvl_c = res[OUT_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ys_s1  <= one_q[F-1] ? (33'h1_0000_0000 >> n_q[F-1])
			                     : ({1'b0, y_q[F-1]} >> n_q[F-1]);
			flg_s1 <= flg_q[F-1];
			lvl_s2 <= lvl_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_q[F-1];
			vld_s2 <= vld_s1;
		end
	end

	assign out_valid = vld_s2;
	assign level     = lvl_s2;

endmodule

// ===== src/gamma_contrast_ramp_core.sv =====
// ----------------------------------------------------------------------------
// gamma_contrast_ramp_core
// Contrast about mid-gray, then x^(1/gamma), one level per unstalled clock.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries one input level per transfer in s_tdata; m_* stream
//   returns the corrected level in m_tdata, one result per input, in order.
//   cfg_* writes gamma_q (index 0) and contrast_q (index 1); cfg_ready is
//   always high. Write only while no levels are in flight.
// Pipeline: contrast multiply and clamp, reciprocal divide by 2^IN_BITS-1
//   forming x, 27 log2 stages (24 squarings), 43 divider stages for the
//   gamma divide, 26 exp2 stages (24 factor multiplies, shift, scale).
// Throughput: one level per cycle while the output is not stalled; every
//   stage is a register stage.
// Stall: the whole pipe holds while m_tvalid is high and m_tready is low;
//   s_tready drops for the same cycles, nothing is dropped or repeated.
// Reset: all stage valids clear, gamma 1.0, contrast 1.0.
// ----------------------------------------------------------------------------
`include "gamma_contrast_ramp_core_defines.svh"

module gamma_contrast_ramp_core import gcr_pkg::*; #(
	parameter int IN_BITS  = 8,
	parameter int OUT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((IN_BITS+7)/8)*8-1:0]      s_tdata,   // level
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [((OUT_BITS+7)/8)*8-1:0]     m_tdata,   // corrected_level
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [7:0]                        cfg_index,
	input  logic [15:0]                       cfg_data
);

	localparam int M   = (1 << IN_BITS) - 1;
	localparam int DEN = M * 32768;
	localparam int NW  = IN_BITS + 19;
	localparam int NUW = IN_BITS + 15;
	localparam int N1  = IN_BITS + 32;
	localparam int N2  = 43;
	// floor(2^N1 / M): estimate of num * 2^17 / M is exact or one low
	localparam logic [32:0] RECIP = 33'((64'd1 << N1) / 64'(M));

	logic [14:0] gamma_q;
	logic [15:0] contrast_q;
	logic        adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q    <= 15'd8192;
			contrast_q <= 16'd16384;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				GCR_REG_GAMMA:    gamma_q    <= cfg_data[14:0];
				GCR_REG_CONTRAST: contrast_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1: num = (2*level - M)*contrast + M*2^14
	logic signed [IN_BITS+1:0] diff;
	logic signed [NW-1:0]      prod;
	logic signed [NW-1:0]      num_s1;
	logic                      vld_s1;

	assign diff = $signed({1'b0, s_tdata[IN_BITS-1:0], 1'b0}) - $signed((IN_BITS+2)'(M));
	assign prod = diff * $signed({1'b0, contrast_q});

	// stage 2: clamp to [0,1]
	logic [IN_BITS+14:0] numu_s2;
	gcr_flags_t          flg_s2;
	logic                vld_s2;
	logic                lo_c;
	logic                hi_c;

	assign lo_c = num_s1 <= $signed(NW'(0));
	assign hi_c = num_s1 >= $signed(NW'(DEN));

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1      <= prod + $signed(NW'(M * 16384));
			numu_s2     <= (lo_c || hi_c) ? '0 : num_s1[IN_BITS+14:0];
			flg_s2.zero <= lo_c;
			flg_s2.full <= hi_c;
		end
	end

	// x = num * 2^17 / M in Q0.32
	// stage 3: reciprocal product
	logic [NUW+31:0] xp_s3;
	logic [NUW-1:0]  numu_s3;
	gcr_flags_t      flg_s3;
	logic            vld_s3;

	// stage 4: remainder check of the estimate, M*q done as shift and subtract
	logic [31:0]     qe_c;
	logic [N1-1:0]   rem_c;
	logic [31:0]     qe_s4;
	logic            inc_s4;
	gcr_flags_t      flg_s4;
	logic            vld_s4;

	// stage 5: corrected quotient
	logic [31:0]     x_s5;
	gcr_flags_t      flg_s5;
	logic            vld_s5;

	assign qe_c  = xp_s3[NUW+31:NUW];
	assign rem_c = {numu_s3, 17'h0} - {qe_c, IN_BITS'(0)} + N1'(qe_c);

	always_ff @(posedge clk) begin
		if (adv) begin
			xp_s3   <= (NUW+32)'(numu_s2) * (NUW+32)'(RECIP);
			numu_s3 <= numu_s2;
			flg_s3  <= flg_s2;
			qe_s4   <= qe_c;
			inc_s4  <= rem_c >= N1'(M);
			flg_s4  <= flg_s3;
			x_s5    <= qe_s4 + 32'(inc_s4);
			flg_s5  <= flg_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	gcr_flags_t    lg_flags;

	assign lg_flags.full = flg_s5.full;
	assign lg_flags.zero = flg_s5.zero || (x_s5 == 32'h0);

	logic        lg_valid;
	logic [29:0] lg_t;
	gcr_flags_t  lg_out_flags;

	gcr_log2 u_log2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s5),
		.x         (x_s5),
		.in_flags  (lg_flags),
		.out_valid (lg_valid),
		.t         (lg_t),
		.out_flags (lg_out_flags)
	);

	// u = t * 2^13 / gamma
	logic [14:0]   g_div;
	logic          d2_valid;
	logic [N2-1:0] d2_q;
	gcr_flags_t    d2_flags;
	gcr_flags_t    ex_flags;

	assign g_div = (gamma_q == 15'd0) ? 15'd1 : gamma_q;

	gcr_div #(.N(N2), .W(15)) u_div_u (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (lg_valid),
		.dividend  ({lg_t, 13'h0}),
		.divisor   (g_div),
		.in_flags  (lg_out_flags),
		.out_valid (d2_valid),
		.quotient  (d2_q),
		.out_flags (d2_flags)
	);

	// results below the output LSB go to zero
	assign ex_flags.full = d2_flags.full;
	assign ex_flags.zero = d2_flags.zero || (d2_q[42:24] >= 19'(OUT_BITS + 2));

	logic                ex_valid;
	logic [OUT_BITS-1:0] ex_level;

	gcr_exp2 #(.OUT_BITS(OUT_BITS)) u_exp2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (d2_valid),
		.n         (d2_q[28:24]),
		.r         (d2_q[23:0]),
		.in_flags  (ex_flags),
		.out_valid (ex_valid),
		.level     (ex_level)
	);

	assign m_tvalid = ex_valid;
	assign m_tdata  = (((OUT_BITS+7)/8)*8)'(ex_level);

	`GCR_CHECK_NEXT(a_stall_holds_result, m_tvalid && !m_tready, m_tvalid)
	`GCR_CHECK(a_stall_blocks_input, m_tvalid && !m_tready |-> !s_tready)

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// gamma_contrast_ramp_core testbench
// Streams pixel levels through the core under several gamma and contrast
// settings and with random source gaps and sink stalls. A bit-exact local
// model of the contrast, log2, divide and exp2 path predicts every corrected
// level, and each m_* transfer is checked in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import gcr_pkg::*;

	localparam int  LAT      = 101;
	localparam int  LFRAC    = 24;
	localparam real HALF_PER = 4.0;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // level
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // corrected_level
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [15:0] cfg_data;

	gamma_contrast_ramp_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// model copy of the registers
	logic [14:0] gamma_reg;
	logic [15:0] contrast_reg;
	logic [31:0] root_tab [1:LFRAC];

	logic [15:0] expected_levels [$];
	int          err_cnt;
	int          sent_cnt;
	int          got_cnt;
	int          cfg_cnt;
	int          src_idle_pct;
	int          snk_stall_pct;
	int          holdoff_req;

	initial clk = 1'b0;
	always #(HALF_PER) clk = ~clk;

	// floor(sqrt(v)) by trial of each result bit
	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [127:0] r;
		logic [127:0] trial;
		r = '0;
		for (int b = 32; b >= 0; b--) begin
			trial = r | (128'd1 << b);
			if (trial * trial <= {64'd0, v})
				r = trial;
		end
		return r[63:0];
	endfunction

	function automatic logic [15:0] corrected_of(input logic [7:0] level);
		longint            m;
		longint            num;
		longint            den;
		longint unsigned   x, mant, frac, t, u, g, y, r, n, res;
		int                p;
		m   = 255;
		num = (2 * longint'(level) - m) * longint'(contrast_reg) + m * 16384;
		den = m * 32768;
		if (num <= 0)
			return 16'd0;
		if (num >= den)
			return 16'hFFFF;
		x = (longint'(num) << 32) / longint'(den);
		if (x == 0)
			return 16'd0;
		g = (gamma_reg == 0) ? 1 : gamma_reg;
		p = 31;
		while (p > 0 && x[p] == 1'b0)
			p--;
		mant = (p <= 30) ? (x << (30 - p)) : (x >> 1);
		frac = 0;
		for (int i = 0; i < LFRAC; i++) begin
			mant = (mant * mant) >> 30;
			frac = frac << 1;
			if (mant >= (64'd2 << 30)) begin
				frac = frac | 1;
				mant = mant >> 1;
			end
		end
		t = (longint'(32 - p) << LFRAC) - frac;
		u = (t << 13) / g;
		n = u >> LFRAC;
		if (n >= 18)
			return 16'd0;
		r = u & ((64'd1 << LFRAC) - 1);
		y = 64'd1 << 32;
		for (int k = 1; k <= LFRAC; k++)
			if (r[LFRAC-k])
				y = (y * root_tab[k]) >> 32;
		y = y >> n[4:0];
		res = (y * 65535 + (64'd1 << 31)) >> 32;
		if (res > 65535)
			res = 65535;
		return res[15:0];
	endfunction

	// sink: random stalls plus an optional long hold-off counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (holdoff_req > 0) begin
			m_tready <= 1'b0;
			holdoff_req <= holdoff_req - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			got_cnt++;
			if (expected_levels.size() == 0) begin
				$error("corrected_level: unexpected result %0d", m_tdata);
				err_cnt++;
			end else begin
				want = expected_levels.pop_front();
				if (m_tdata !== want) begin
					$error("corrected_level: expected %0d actual %0d", want, m_tdata);
					err_cnt++;
				end
			end
		end
	end

	task automatic send_level(input logic [7:0] level);
		logic rdy;
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= level;
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		expected_levels.insert(expected_levels.size(), corrected_of(level));
		sent_cnt++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (LAT + 10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		logic rdy;
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
		if (idx == GCR_REG_GAMMA)
			gamma_reg = val[14:0];
		else if (idx == GCR_REG_CONTRAST)
			contrast_reg = val;
		cfg_cnt++;
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(9))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'($urandom_range(0, 8));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic test_directed();
		logic [7:0] lv [12] = '{8'd0, 8'd1, 8'd2, 8'd4, 8'd16, 8'd64, 8'd127,
			8'd128, 8'd170, 8'd85, 8'd254, 8'd255};
		foreach (lv[i])
			send_level(lv[i]);
		// steep gamma: tiny results near black
		write_reg(GCR_REG_GAMMA, 16'd2458);
		send_level(8'd1); send_level(8'd3); send_level(8'd200);
		// zero gamma treated as one LSB
		write_reg(GCR_REG_GAMMA, 16'd0);
		send_level(8'd200); send_level(8'd254);
		// top bit of data is dropped for gamma
		write_reg(GCR_REG_GAMMA, 16'hFFFF);
		send_level(8'd10); send_level(8'd128);
		// zero contrast: mid gray everywhere
		write_reg(GCR_REG_CONTRAST, 16'd0);
		send_level(8'd0); send_level(8'd255);
		// maximum contrast saturates the high end
		write_reg(GCR_REG_CONTRAST, 16'hFFFF);
		send_level(8'd100); send_level(8'd128); send_level(8'd160);
		// unknown indexes leave the registers alone
		write_reg(8'd2, 16'h1234);
		write_reg(8'hFF, 16'hEDCB);
		send_level(8'd129);
	endtask

	task automatic test_random();
		int idle [4]  = '{0, 55, 0, 13};
		int stall [4] = '{0, 0, 55, 13};
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct  = 0;
			snk_stall_pct = 0;
			case (ph)
				0: begin
					write_reg(GCR_REG_GAMMA, 16'd22938);
					write_reg(GCR_REG_CONTRAST, 16'd8192);
				end
				1: begin
					write_reg(GCR_REG_GAMMA, 16'd2458);
					write_reg(GCR_REG_CONTRAST, 16'd32768);
				end
				default: begin
					write_reg(GCR_REG_GAMMA, 16'($urandom_range(2458, 22938)));
					write_reg(GCR_REG_CONTRAST, 16'($urandom_range(8192, 32768)));
				end
			endcase
			src_idle_pct  = idle[ph];
			snk_stall_pct = stall[ph];
			for (int i = 0; i < 50; i++)
				send_level(pick_level());
			// a burst with no source gaps inside the phase
			src_idle_pct = 0;
			for (int i = 0; i < 10; i++)
				send_level(pick_level());
		end
		src_idle_pct  = 0;
		snk_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		write_reg(GCR_REG_GAMMA, 16'd8192);
		write_reg(GCR_REG_CONTRAST, 16'd16384);
		@(negedge clk);
		holdoff_req = 400;
		@(posedge clk);
		for (int i = 0; i < 140; i++)
			send_level(8'($urandom_range(0, 255)));
	endtask

	initial begin
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		holdoff_req   = 0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		err_cnt       = 0;
		sent_cnt      = 0;
		got_cnt       = 0;
		cfg_cnt       = 0;
		gamma_reg     = 15'd8192;
		contrast_reg  = 16'd16384;
		begin
			logic [63:0] c;
			c = 64'd1 << 31;
			for (int k = 1; k <= LFRAC; k++) begin
				c = floor_sqrt(c << 32);
				root_tab[k] = c[31:0];
			end
		end
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random();
		test_backpressure();
		drain();

		if (expected_levels.size() != 0)
			err_cnt++;
		$display("covered %0d levels, %0d results, %0d register writes", sent_cnt, got_cnt,
			cfg_cnt);
		$display("phases: directed corners, four idle/stall mixes, long sink hold-off");
		if (err_cnt == 0)
			$display("gamma_contrast_ramp_core regression: pass");
		else
			$display("gamma_contrast_ramp_core regression: fail");
		$finish;
	end

	initial begin
		#4ms;
		$display("gamma_contrast_ramp_core regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/gcr_pkg.sv
src/gcr_div.sv
src/gcr_log2.sv
src/gcr_exp2.sv
src/gamma_contrast_ramp_core.sv
sim/testbench.sv
